// ----- src/array_linked_list_manager_unit_assert.svh -----
// Assertion macros for the array linked list manager
`ifndef ARRAY_LINKED_LIST_MANAGER_UNIT_ASSERT_SVH
`define ARRAY_LINKED_LIST_MANAGER_UNIT_ASSERT_SVH

// same-cycle implication
`define ALLM_CHK(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("array linked list manager check failed");

// next-cycle implication
`define ALLM_CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("array linked list manager check failed");

`endif

// ----- src/allm_pkg.sv -----
// Package: types and constants of the array linked list manager
`timescale 1ns / 1ps
package allm_pkg;

  localparam int ENTRIES_DEF = 1024;
  localparam int DATA_BITS_DEF = 32;
  localparam logic [31:0] RESERVED_RESET = 32'h333C0CA1;

  typedef enum logic [3:0] {
    MODE_INS_AFTER  = 4'd0,
    MODE_INS_BEFORE = 4'd1,
    MODE_PUSH_FRONT = 4'd2,
    MODE_PUSH_BACK  = 4'd3,
    MODE_ERASE      = 4'd4,
    MODE_POP_FRONT  = 4'd5,
    MODE_POP_BACK   = 4'd6,
    MODE_READ       = 4'd7,
    MODE_FIND       = 4'd8,
    MODE_LOCATE     = 4'd9,
    MODE_LINEARIZE  = 4'd10
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RESERVED = 2'd1,
    ST_FULL     = 2'd2,
    ST_INVALID  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_DISPATCH,
    S_READ_POS,
    S_INS_A,
    S_INS_B,
    S_INS_C,
    S_INS_D,
    S_ERA_A,
    S_ERA_B,
    S_FIND,
    S_LOC,
    S_LIN_W,
    S_LIN_R,
    S_FIN
  } fsm_t;

endpackage

// ----- src/allm_ram.sv -----
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module allm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/array_linked_list_manager_unit.sv -----
// Top level: doubly linked list with free chain kept in entry RAMs
// After reset the block sweeps every entry of the link RAMs before taking its first item.
// One item at a time runs through a read-modify-write sequencer over RAMs with registered read
// data. Find and locate walk the list one entry at a time, and linearize copies each list element
// into the other data bank, then rebuilds the link RAMs from entry 1 up. The next item is taken
// in the cycle after the output register loads; a result still waiting in that register holds
// the sequencer back.
// Configuration transfers are taken in any cycle.
`timescale 1ns / 1ps
module array_linked_list_manager_unit #(
  parameter int ENTRIES = allm_pkg::ENTRIES_DEF,
  parameter int DATA_BITS = allm_pkg::DATA_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic signed [31:0] cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         mode,
  input  logic [9:0]         position,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic [9:0]         result_index,
  output logic signed [31:0] data_out,
  output logic [9:0]         next_out,
  output logic [9:0]         prev_out,
  output logic [9:0]         first_entry,
  output logic [9:0]         last_entry,
  output logic [9:0]         element_count
);

  localparam int IW = $clog2(ENTRIES);
  localparam int DB = DATA_BITS;

  allm_pkg::fsm_t state, state_next;

  logic [31:0]   reserved;
  logic [3:0]    op;
  logic [9:0]    pos;
  logic [DB-1:0] val;
  logic [IW-1:0] t, p, e, fe_next, nx, pv, cur, k, n, sweep;
  logic          stays;
  logic [IW-1:0] head, tail, free_head, count;
  logic          bank, is_lin;
  logic [1:0]    r_status;
  logic [IW-1:0] r_idx, r_nx, r_pv;
  logic [31:0]   r_dout;

  logic [IW-1:0] raddr;
  logic          nxt_we, prv_we, use_we;
  logic [IW-1:0] nxt_waddr, prv_waddr, use_waddr, nxt_wdata, prv_wdata;
  logic          use_wdata;
  logic [IW-1:0] nxt_rd, prv_rd;
  logic          use_rd;
  logic [1:0]    dat_we;
  logic [IW-1:0] dat_waddr;
  logic [DB-1:0] dat_wdata, dat_rd_a, dat_rd_b, dat_src;

  logic [IW-1:0] pidx;
  logic          pos_in, rsv_hit, walk_end, fin_go;
  logic [IW:0]   sweep1, n1;
  logic [IW-1:0] ins_nx;

  assign pidx    = IW'(32'(pos));
  assign pos_in  = 32'(pos) < ENTRIES;
  assign rsv_hit = (op <= 4'(allm_pkg::MODE_PUSH_BACK)) && (val == DB'($unsigned(reserved)));
  assign dat_src = bank ? dat_rd_b : dat_rd_a;
  assign sweep1  = {1'b0, sweep} + 1'b1;
  assign n1      = {1'b0, n} + 1'b1;
  assign ins_nx  = (p == '0) ? head : nxt_rd;
  assign walk_end = (nxt_rd == '0);
  assign fin_go  = !out_valid || out_ready;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == allm_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      reserved <= allm_pkg::RESERVED_RESET;
    end else if (cfg_valid) begin
      reserved <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= allm_pkg::S_CLR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    raddr = pidx;
    nxt_we = 1'b0; nxt_waddr = '0; nxt_wdata = '0;
    prv_we = 1'b0; prv_waddr = '0; prv_wdata = '0;
    use_we = 1'b0; use_waddr = '0; use_wdata = 1'b0;
    dat_we = 2'b00; dat_waddr = '0; dat_wdata = '0;
    unique case (state)
      allm_pkg::S_CLR: begin
        nxt_we = 1'b1; nxt_waddr = sweep;
        nxt_wdata = (sweep1 == (IW+1)'(ENTRIES)) ? '0 : sweep1[IW-1:0];
        prv_we = 1'b1; prv_waddr = sweep;
        use_we = 1'b1; use_waddr = sweep;
        if (sweep1 == (IW+1)'(ENTRIES)) state_next = allm_pkg::S_IDLE;
      end
      allm_pkg::S_IDLE: begin
        if (in_valid) state_next = allm_pkg::S_DISPATCH;
      end
      allm_pkg::S_DISPATCH: begin
        state_next = allm_pkg::S_FIN;
        if (!rsv_hit) begin
          case (op) inside
            allm_pkg::MODE_INS_AFTER, allm_pkg::MODE_INS_BEFORE: begin
              if (pos_in && pidx == '0) state_next = allm_pkg::S_INS_A;
              else if (pos_in) state_next = allm_pkg::S_READ_POS;
            end
            allm_pkg::MODE_ERASE: begin
              if (pos_in && pidx != '0) state_next = allm_pkg::S_READ_POS;
            end
            allm_pkg::MODE_READ: begin
              if (pos_in && pidx != '0) state_next = allm_pkg::S_READ_POS;
            end
            allm_pkg::MODE_PUSH_FRONT, allm_pkg::MODE_PUSH_BACK: state_next = allm_pkg::S_INS_A;
            allm_pkg::MODE_POP_FRONT: begin
              raddr = head;
              if (head != '0) state_next = allm_pkg::S_READ_POS;
            end
            allm_pkg::MODE_POP_BACK: begin
              raddr = tail;
              if (tail != '0) state_next = allm_pkg::S_READ_POS;
            end
            allm_pkg::MODE_FIND: begin
              raddr = head;
              if (head != '0) state_next = allm_pkg::S_FIND;
            end
            allm_pkg::MODE_LOCATE: begin
              raddr = head;
              if (32'(pos) < 32'(count) && pos != '0) state_next = allm_pkg::S_LOC;
            end
            allm_pkg::MODE_LINEARIZE: begin
              raddr = head;
              if (count != '0) state_next = allm_pkg::S_LIN_W;
            end
            default: state_next = allm_pkg::S_FIN;
          endcase
        end
      end
      allm_pkg::S_READ_POS: begin
        state_next = allm_pkg::S_FIN;
        if (use_rd) begin
          case (op) inside
            allm_pkg::MODE_INS_AFTER, allm_pkg::MODE_INS_BEFORE: state_next = allm_pkg::S_INS_A;
            allm_pkg::MODE_ERASE, allm_pkg::MODE_POP_FRONT, allm_pkg::MODE_POP_BACK:
              state_next = allm_pkg::S_ERA_A;
            default: state_next = allm_pkg::S_FIN;
          endcase
        end
      end
      allm_pkg::S_INS_A: begin
        raddr = free_head;
        state_next = (free_head == '0) ? allm_pkg::S_FIN : allm_pkg::S_INS_B;
      end
      allm_pkg::S_INS_B: begin
        raddr = p;
        state_next = allm_pkg::S_INS_C;
      end
      allm_pkg::S_INS_C: begin
        nxt_we = 1'b1; nxt_waddr = e; nxt_wdata = ins_nx;
        prv_we = 1'b1; prv_waddr = e; prv_wdata = p;
        use_we = 1'b1; use_waddr = e; use_wdata = 1'b1;
        dat_we = bank ? 2'b10 : 2'b01; dat_waddr = e; dat_wdata = val;
        state_next = allm_pkg::S_INS_D;
      end
      allm_pkg::S_INS_D: begin
        nxt_we = (p != '0); nxt_waddr = p; nxt_wdata = e;
        prv_we = (nx != '0); prv_waddr = nx; prv_wdata = e;
        state_next = allm_pkg::S_FIN;
      end
      allm_pkg::S_ERA_A: begin
        nxt_we = (pv != '0); nxt_waddr = pv; nxt_wdata = nx;
        prv_we = (nx != '0); prv_waddr = nx; prv_wdata = pv;
        state_next = allm_pkg::S_ERA_B;
      end
      allm_pkg::S_ERA_B: begin
        nxt_we = 1'b1; nxt_waddr = t; nxt_wdata = free_head;
        prv_we = 1'b1; prv_waddr = t;
        use_we = 1'b1; use_waddr = t;
        state_next = allm_pkg::S_FIN;
      end
      allm_pkg::S_FIND: begin
        raddr = nxt_rd;
        if (dat_src == val || walk_end) state_next = allm_pkg::S_FIN;
      end
      allm_pkg::S_LOC: begin
        raddr = nxt_rd;
        if (32'(k) == 32'(pos)) state_next = allm_pkg::S_FIN;
      end
      allm_pkg::S_LIN_W: begin
        raddr = nxt_rd;
        dat_we = bank ? 2'b01 : 2'b10; dat_waddr = n1[IW-1:0]; dat_wdata = dat_src;
        if (walk_end || n1 + 1'b1 >= (IW+1)'(ENTRIES)) state_next = allm_pkg::S_LIN_R;
      end
      allm_pkg::S_LIN_R: begin
        nxt_we = 1'b1; nxt_waddr = sweep;
        prv_we = 1'b1; prv_waddr = sweep;
        use_we = 1'b1; use_waddr = sweep;
        if (sweep <= n) begin
          nxt_wdata = (sweep < n) ? sweep1[IW-1:0] : '0;
          prv_wdata = sweep - 1'b1;
          use_wdata = 1'b1;
        end else begin
          nxt_wdata = (sweep1 == (IW+1)'(ENTRIES)) ? '0 : sweep1[IW-1:0];
        end
        if (sweep1 == (IW+1)'(ENTRIES)) state_next = allm_pkg::S_FIN;
      end
      allm_pkg::S_FIN: begin
        if (fin_go) state_next = allm_pkg::S_IDLE;
      end
      default: state_next = allm_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep <= '0;
      head <= '0; tail <= '0; free_head <= IW'(1); count <= '0;
      bank <= 1'b0; is_lin <= 1'b1; out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != allm_pkg::S_FIN) out_valid <= 1'b0;
      case (state)
        allm_pkg::S_CLR: sweep <= sweep1[IW-1:0];
        allm_pkg::S_IDLE: begin
          op <= mode; pos <= position; val <= DB'($unsigned(value));
          r_status <= allm_pkg::ST_OK;
          r_idx <= '0; r_dout <= '0; r_nx <= '0; r_pv <= '0;
        end
        allm_pkg::S_DISPATCH: begin
          cur <= head; k <= IW'(1); n <= '0;
          t <= pidx;
          if (rsv_hit) begin
            r_status <= allm_pkg::ST_RESERVED;
          end else begin
            case (op)
              allm_pkg::MODE_INS_AFTER: begin
                p <= '0;
                if (!pos_in) r_status <= allm_pkg::ST_INVALID;
              end
              allm_pkg::MODE_INS_BEFORE: begin
                p <= tail;
                if (!pos_in) r_status <= allm_pkg::ST_INVALID;
              end
              allm_pkg::MODE_PUSH_FRONT: p <= '0;
              allm_pkg::MODE_PUSH_BACK: p <= tail;
              allm_pkg::MODE_ERASE: begin
                if (!pos_in || pidx == '0) r_status <= allm_pkg::ST_INVALID;
              end
              allm_pkg::MODE_POP_FRONT: begin
                t <= head;
                if (head == '0) r_status <= allm_pkg::ST_INVALID;
              end
              allm_pkg::MODE_POP_BACK: begin
                t <= tail;
                if (tail == '0) r_status <= allm_pkg::ST_INVALID;
              end
              allm_pkg::MODE_READ: begin
                if (!pos_in) begin
                  r_status <= allm_pkg::ST_INVALID;
                end else if (pidx == '0) begin
                  r_dout <= reserved; r_nx <= head; r_pv <= tail;
                end
              end
              allm_pkg::MODE_FIND: ;
              allm_pkg::MODE_LOCATE: begin
                if (32'(pos) >= 32'(count)) r_status <= allm_pkg::ST_INVALID;
                else if (pos == '0) r_idx <= head;
              end
              allm_pkg::MODE_LINEARIZE: begin
                if (count == '0) is_lin <= 1'b1;
              end
              default: r_status <= allm_pkg::ST_INVALID;
            endcase
          end
        end
        allm_pkg::S_READ_POS: begin
          nx <= nxt_rd; pv <= prv_rd;
          if (op == 4'(allm_pkg::MODE_INS_AFTER)) p <= t;
          if (op == 4'(allm_pkg::MODE_INS_BEFORE)) p <= prv_rd;
          if (!use_rd) begin
            r_status <= allm_pkg::ST_INVALID;
          end else if (op == 4'(allm_pkg::MODE_READ)) begin
            r_dout <= 32'(dat_src); r_nx <= nxt_rd; r_pv <= prv_rd;
          end
        end
        allm_pkg::S_INS_A: begin
          e <= free_head;
          if (free_head == '0) r_status <= allm_pkg::ST_FULL;
        end
        allm_pkg::S_INS_B: fe_next <= nxt_rd;
        allm_pkg::S_INS_C: begin
          nx <= ins_nx;
          free_head <= fe_next;
          stays <= is_lin && ({1'b0, e} == {1'b0, p} + 1'b1) && (ins_nx == '0);
        end
        allm_pkg::S_INS_D: begin
          if (p == '0) head <= e;
          if (nx == '0) tail <= e;
          count <= count + 1'b1;
          is_lin <= stays;
          r_idx <= e;
        end
        allm_pkg::S_ERA_A: begin
          stays <= is_lin && (t == tail);
          if (pv == '0) head <= nx;
          if (nx == '0) tail <= pv;
        end
        allm_pkg::S_ERA_B: begin
          free_head <= t;
          count <= count - 1'b1;
          is_lin <= stays;
        end
        allm_pkg::S_FIND: begin
          cur <= nxt_rd;
          if (dat_src == val) r_idx <= cur;
        end
        allm_pkg::S_LOC: begin
          k <= k + 1'b1;
          if (32'(k) == 32'(pos)) r_idx <= nxt_rd;
        end
        allm_pkg::S_LIN_W: begin
          n <= n1[IW-1:0];
          sweep <= IW'(1);
        end
        allm_pkg::S_LIN_R: begin
          sweep <= sweep1[IW-1:0];
          if (sweep1 == (IW+1)'(ENTRIES)) begin
            head <= IW'(1); tail <= n; count <= n;
            free_head <= (n1 < (IW+1)'(ENTRIES)) ? n1[IW-1:0] : '0;
            bank <= ~bank; is_lin <= 1'b1;
          end
        end
        allm_pkg::S_FIN: begin
          if (fin_go) begin
            out_valid <= 1'b1;
            status <= r_status;
            result_index <= 10'(r_idx);
            data_out <= r_dout;
            next_out <= 10'(r_nx);
            prev_out <= 10'(r_pv);
            first_entry <= 10'(head);
            last_entry <= 10'(tail);
            element_count <= 10'(count);
          end
        end
        default: ;
      endcase
    end
  end

  allm_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_next_ram (
    .clk(clk), .we(nxt_we), .waddr(nxt_waddr), .wdata(nxt_wdata), .raddr(raddr), .rdata(nxt_rd)
  );

  allm_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_prev_ram (
    .clk(clk), .we(prv_we), .waddr(prv_waddr), .wdata(prv_wdata), .raddr(raddr), .rdata(prv_rd)
  );

  allm_ram #(.WIDTH(1), .DEPTH(ENTRIES)) u_use_ram (
    .clk(clk), .we(use_we), .waddr(use_waddr), .wdata(use_wdata), .raddr(raddr), .rdata(use_rd)
  );

  allm_ram #(.WIDTH(DB), .DEPTH(ENTRIES)) u_data_a_ram (
    .clk(clk), .we(dat_we[0]), .waddr(dat_waddr), .wdata(dat_wdata), .raddr(raddr),
    .rdata(dat_rd_a)
  );

  allm_ram #(.WIDTH(DB), .DEPTH(ENTRIES)) u_data_b_ram (
    .clk(clk), .we(dat_we[1]), .waddr(dat_waddr), .wdata(dat_wdata), .raddr(raddr),
    .rdata(dat_rd_b)
  );

endmodule

// ----- src/allm_checker.sv -----
// Checker on the top level ports of the array linked list manager, with its bind
`timescale 1ns / 1ps
`include "array_linked_list_manager_unit_assert.svh"
module allm_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         status,
  input logic [9:0]         result_index,
  input logic [9:0]         first_entry,
  input logic [9:0]         last_entry,
  input logic [9:0]         element_count
);

  `ALLM_CHK_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(result_index))
  `ALLM_CHK(a_empty_ends, out_valid && element_count == 10'd0, first_entry == 10'd0 && last_entry == 10'd0)
  `ALLM_CHK(a_full_ends, out_valid && element_count != 10'd0, first_entry != 10'd0 && last_entry != 10'd0)
  `ALLM_CHK(a_reject_idx, out_valid && status == allm_pkg::ST_RESERVED, result_index == 10'd0)

endmodule

bind array_linked_list_manager_unit allm_checker u_allm_checker (.*);

// ----- test/tb_array_linked_list_manager_unit.sv -----
// Testbench for the array linked list manager: predicts and checks every result
`timescale 1ns / 1ps
module tb_array_linked_list_manager_unit;

  localparam int NENT = 1024;

  typedef struct {
    logic [3:0]  m;
    logic [9:0]  pos;
    logic [31:0] val;
  } op_t;

  typedef struct {
    allm_pkg::status_t st;
    logic [9:0]  idx;
    logic [31:0] dout;
    logic [9:0]  nx;
    logic [9:0]  pv;
    logic [9:0]  head;
    logic [9:0]  tail;
    logic [9:0]  cnt;
  } reply_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic signed [31:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_ready;
  logic [3:0] mode = '0;
  logic [9:0] position = '0;
  logic signed [31:0] value = '0;
  logic out_valid;
  logic out_ready = 0;
  logic [1:0] status;
  logic [9:0] result_index;
  logic signed [31:0] data_out;
  logic [9:0] next_out;
  logic [9:0] prev_out;
  logic [9:0] first_entry;
  logic [9:0] last_entry;
  logic [9:0] element_count;

  array_linked_list_manager_unit dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .position(position), .value(value),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .result_index(result_index), .data_out(data_out),
    .next_out(next_out), .prev_out(prev_out), .first_entry(first_entry),
    .last_entry(last_entry), .element_count(element_count)
  );

  always #4 clk = ~clk;

  // list shadow
  logic [31:0] bank [2][NENT];
  logic        sel;
  logic [9:0]  nxt [NENT];
  logic [9:0]  prv [NENT];
  logic        used [NENT];
  logic [9:0]  free_head;
  int          cnt;
  logic        lin;
  logic [31:0] rsv;

  op_t    pending[$];
  reply_t replies_due[$];
  int     errors = 0;
  bit     idle_on = 1;

  function automatic void rebuild_free(int first);
    for (int i = first; i < NENT; i++) begin
      nxt[i] = (i + 1 < NENT) ? 10'(i + 1) : '0;
      prv[i] = '0;
      used[i] = 0;
    end
    free_head = (first < NENT) ? 10'(first) : '0;
  endfunction

  function automatic allm_pkg::status_t link_after(logic [9:0] p, logic [31:0] v,
                                                   output logic [9:0] e);
    logic [9:0] n;
    logic stays;
    e = '0;
    if (free_head == 0) return allm_pkg::ST_FULL;
    e = free_head;
    free_head = nxt[e];
    n = nxt[p];
    stays = lin && (int'(e) == int'(p) + 1) && n == 0;
    nxt[e] = n;
    prv[e] = p;
    bank[sel][e] = v;
    used[e] = 1;
    nxt[p] = e;
    prv[n] = e;
    cnt++;
    lin = stays;
    return allm_pkg::ST_OK;
  endfunction

  function automatic allm_pkg::status_t unlink(logic [9:0] p);
    logic [9:0] n, b;
    logic stays;
    if (p == 0 || !used[p]) return allm_pkg::ST_INVALID;
    stays = lin && p == prv[0];
    n = nxt[p];
    b = prv[p];
    nxt[b] = n;
    prv[n] = b;
    nxt[p] = free_head;
    prv[p] = '0;
    used[p] = 0;
    free_head = p;
    cnt--;
    lin = stays;
    return allm_pkg::ST_OK;
  endfunction

  function automatic void compact();
    logic dst;
    logic [9:0] cur;
    int n;
    if (cnt == 0) begin
      lin = 1;
      return;
    end
    dst = ~sel;
    cur = nxt[0];
    n = 0;
    while (cur != 0 && n + 1 < NENT) begin
      n++;
      bank[dst][n] = bank[sel][cur];
      cur = nxt[cur];
    end
    for (int i = 1; i <= n; i++) begin
      prv[i] = 10'(i - 1);
      nxt[i] = (i < n) ? 10'(i + 1) : '0;
      used[i] = 1;
    end
    nxt[0] = 10'd1;
    prv[0] = 10'(n);
    cnt = n;
    rebuild_free(n + 1);
    sel = dst;
    lin = 1;
  endfunction

  function automatic reply_t list_op(op_t o);
    reply_t r;
    logic [9:0] cur;
    r = '{allm_pkg::ST_OK, '0, '0, '0, '0, '0, '0, '0};
    if (o.m <= allm_pkg::MODE_PUSH_BACK && o.val == rsv) begin
      r.st = allm_pkg::ST_RESERVED;
    end else begin
      case (o.m)
        allm_pkg::MODE_INS_AFTER:
          r.st = (o.pos == 0 || used[o.pos]) ? link_after(o.pos, o.val, r.idx)
                                             : allm_pkg::ST_INVALID;
        allm_pkg::MODE_INS_BEFORE:
          r.st = (o.pos == 0 || used[o.pos]) ? link_after(prv[o.pos], o.val, r.idx)
                                             : allm_pkg::ST_INVALID;
        allm_pkg::MODE_PUSH_FRONT: r.st = link_after('0, o.val, r.idx);
        allm_pkg::MODE_PUSH_BACK:  r.st = link_after(prv[0], o.val, r.idx);
        allm_pkg::MODE_ERASE:      r.st = unlink(o.pos);
        allm_pkg::MODE_POP_FRONT:  r.st = unlink(nxt[0]);
        allm_pkg::MODE_POP_BACK:   r.st = unlink(prv[0]);
        allm_pkg::MODE_READ: begin
          if (o.pos == 0) begin
            r.dout = rsv;
            r.nx = nxt[0];
            r.pv = prv[0];
          end else if (used[o.pos]) begin
            r.dout = bank[sel][o.pos];
            r.nx = nxt[o.pos];
            r.pv = prv[o.pos];
          end else begin
            r.st = allm_pkg::ST_INVALID;
          end
        end
        allm_pkg::MODE_FIND: begin
          cur = nxt[0];
          for (int k = 0; cur != 0 && k < NENT; k++) begin
            if (bank[sel][cur] == o.val) begin
              r.idx = cur;
              break;
            end
            cur = nxt[cur];
          end
        end
        allm_pkg::MODE_LOCATE: begin
          if (o.pos >= cnt) begin
            r.st = allm_pkg::ST_INVALID;
          end else begin
            cur = nxt[0];
            for (int k = 0; k < o.pos && cur != 0; k++) cur = nxt[cur];
            r.idx = cur;
          end
        end
        allm_pkg::MODE_LINEARIZE: compact();
        default: r.st = allm_pkg::ST_INVALID;
      endcase
    end
    r.head = nxt[0];
    r.tail = prv[0];
    r.cnt = 10'(cnt);
    return r;
  endfunction

  // input driver
  always @(posedge clk) begin
    op_t o;
    op_t a;
    if (!rst) begin
      if (in_valid && in_ready) begin
        a = '{mode, position, value};
        replies_due.insert(replies_due.size(), list_op(a));
      end
      if (!in_valid || in_ready) begin
        if (pending.size() > 0 && !(idle_on && $urandom_range(99) < 12)) begin
          o = pending[0];
          pending.delete(0);
          in_valid <= 1;
          mode <= o.m;
          position <= o.pos;
          value <= o.val;
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    reply_t w;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (replies_due.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result transfer: status %0d", status);
        end else begin
          w = replies_due[0];
          replies_due.delete(0);
          if (status != w.st || result_index != w.idx || data_out != w.dout ||
              next_out != w.nx || prev_out != w.pv || first_entry != w.head ||
              last_entry != w.tail || element_count != w.cnt) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp st=%0d idx=%0d d=%h n=%0d p=%0d h=%0d t=%0d c=%0d",
                       w.st, w.idx, w.dout, w.nx, w.pv, w.head, w.tail, w.cnt,
                       " got st=%0d idx=%0d d=%h n=%0d p=%0d h=%0d t=%0d c=%0d",
                       status, result_index, data_out, next_out, prev_out,
                       first_entry, last_entry, element_count);
          end
        end
      end
      out_ready <= !(idle_on && $urandom_range(99) < 12);
    end
  end

  task automatic send(logic [3:0] m, logic [9:0] p, logic [31:0] v);
    op_t o;
    o = '{m, p, v};
    pending.insert(pending.size(), o);
    while (pending.size() > 0) @(negedge clk);
  endtask

  task automatic drain();
    while (pending.size() > 0 || in_valid || replies_due.size() > 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  task automatic write_reserved(logic [31:0] v);
    @(posedge clk);
    cfg_valid <= 1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    rsv = v;
  endtask

  function automatic logic [9:0] live_entry();
    logic [9:0] cur;
    int k;
    if (cnt == 0) return 10'($urandom_range(NENT - 1));
    k = $urandom_range(cnt - 1);
    cur = nxt[0];
    repeat (k) cur = nxt[cur];
    return cur;
  endfunction

  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 3) return rsv;
    if (r < 50) return 32'($urandom_range(1, 16));
    if (r < 53) return 32'h8000_0000;
    if (r < 56) return 32'h7fff_ffff;
    return $urandom;
  endfunction

  task automatic random_op();
    int r;
    logic [9:0] p;
    r = $urandom_range(99);
    p = ($urandom_range(9) < 8) ? live_entry() : 10'($urandom_range(NENT - 1));
    if (cnt > 60 && r < 30) r = r + 30;
    if (r < 8)       send(allm_pkg::MODE_INS_AFTER, p, pick_value());
    else if (r < 16) send(allm_pkg::MODE_INS_BEFORE, p, pick_value());
    else if (r < 23) send(allm_pkg::MODE_PUSH_FRONT, 10'($urandom), pick_value());
    else if (r < 30) send(allm_pkg::MODE_PUSH_BACK, 10'($urandom), pick_value());
    else if (r < 40) send(allm_pkg::MODE_ERASE, p, $urandom);
    else if (r < 45) send(allm_pkg::MODE_POP_FRONT, 10'($urandom), $urandom);
    else if (r < 50) send(allm_pkg::MODE_POP_BACK, 10'($urandom), $urandom);
    else if (r < 66) send(allm_pkg::MODE_READ, p, $urandom);
    else if (r < 78) send(allm_pkg::MODE_FIND, 10'($urandom), pick_value());
    else if (r < 90) send(allm_pkg::MODE_LOCATE, 10'($urandom_range(cnt + 2)), $urandom);
    else if (r < 93) send(allm_pkg::MODE_LINEARIZE, 10'($urandom), $urandom);
    else if (r < 95) send(4'($urandom_range(11, 15)), 10'($urandom), $urandom);
    else             send(allm_pkg::MODE_READ, 10'($urandom_range(NENT - 1)), $urandom);
  endtask

  initial begin
    sel = 0;
    nxt[0] = '0;
    prv[0] = '0;
    used[0] = 0;
    rebuild_free(1);
    cnt = 0;
    lin = 1;
    rsv = allm_pkg::RESERVED_RESET;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(negedge clk);

    // directed
    send(allm_pkg::MODE_LINEARIZE, '0, '0);
    send(allm_pkg::MODE_POP_FRONT, '0, '0);
    send(allm_pkg::MODE_POP_BACK, '0, '0);
    send(allm_pkg::MODE_PUSH_BACK, '0, allm_pkg::RESERVED_RESET);
    send(allm_pkg::MODE_PUSH_BACK, '0, 32'h8000_0000);
    send(allm_pkg::MODE_PUSH_FRONT, '0, 32'h7fff_ffff);
    send(allm_pkg::MODE_INS_AFTER, '0, 32'hffff_ffff);
    send(allm_pkg::MODE_INS_BEFORE, '0, 32'h0);
    send(allm_pkg::MODE_INS_AFTER, 10'd1023, 32'd5);
    send(allm_pkg::MODE_INS_BEFORE, 10'd2, 32'd6);
    send(allm_pkg::MODE_ERASE, '0, '0);
    send(allm_pkg::MODE_ERASE, 10'd1023, '0);
    send(allm_pkg::MODE_READ, '0, '0);
    send(allm_pkg::MODE_READ, 10'd1023, '0);
    send(allm_pkg::MODE_READ, 10'd2, '0);
    send(allm_pkg::MODE_FIND, '0, 32'h1234_5678);
    send(allm_pkg::MODE_FIND, '0, 32'h8000_0000);
    send(allm_pkg::MODE_LOCATE, 10'd2, '0);
    send(allm_pkg::MODE_LOCATE, 10'd1023, '0);
    send(4'd11, '0, '0);
    send(4'd15, 10'd1023, 32'hffff_ffff);
    send(allm_pkg::MODE_ERASE, 10'd3, '0);
    send(allm_pkg::MODE_LINEARIZE, '0, '0);
    drain();

    // extreme settings
    write_reserved(32'h8000_0000);
    send(allm_pkg::MODE_PUSH_FRONT, '0, 32'h8000_0000);
    send(allm_pkg::MODE_READ, '0, '0);
    drain();
    write_reserved(32'h7fff_ffff);
    send(allm_pkg::MODE_PUSH_BACK, '0, 32'h7fff_ffff);
    send(allm_pkg::MODE_READ, '0, '0);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      write_reserved((ph == 0) ? allm_pkg::RESERVED_RESET : $urandom_range(1, 16));
      for (int n = 0; n < 35; n++) random_op();
      drain();
    end

    // fill the store to the last entry, then empty part of it
    write_reserved(allm_pkg::RESERVED_RESET);
    idle_on = 0;
    while (cnt < NENT - 1) send(allm_pkg::MODE_PUSH_BACK, '0, $urandom_range(1, 16));
    send(allm_pkg::MODE_PUSH_FRONT, '0, 32'd3);
    send(allm_pkg::MODE_INS_AFTER, 10'd1023, 32'd3);
    send(allm_pkg::MODE_FIND, '0, 32'h7fff_fff0);
    send(allm_pkg::MODE_LOCATE, 10'd1022, '0);
    send(allm_pkg::MODE_READ, 10'd1023, '0);
    send(allm_pkg::MODE_LINEARIZE, '0, '0);
    repeat (10) send(($urandom_range(1) != 0) ? allm_pkg::MODE_POP_BACK
                                               : allm_pkg::MODE_POP_FRONT, '0, '0);
    idle_on = 1;
    drain();

    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #200ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- array_linked_list_manager_unit.f -----
+incdir+src
src/allm_pkg.sv
src/allm_ram.sv
src/array_linked_list_manager_unit.sv
src/allm_checker.sv
test/tb_array_linked_list_manager_unit.sv
